// ----- hdl/slps_pkg.sv -----
// ----------------------------------------------------------------------------
// slps_pkg
// shared types, constants and colour tables of the status led sequencer
// ----------------------------------------------------------------------------
package slps_pkg;

    // strip length, 1 to 64
    localparam int PIXEL_COUNT = 8;
    localparam int PIX_W       = 6;
    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);

    // command codes
    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_MODE  = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;
    localparam logic [1:0] OP_OFF   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_FRAME  = 2'd1;
    localparam logic [1:0] REG_HOLD   = 2'd2;

    // pattern styles
    localparam logic [1:0] STYLE_DARK  = 2'd0;
    localparam logic [1:0] STYLE_SOLID = 2'd1;
    localparam logic [1:0] STYLE_CHASE = 2'd2;
    localparam logic [1:0] STYLE_BLINK = 2'd3;

    localparam logic [15:0] FRAME_MS_RST = 16'd120;
    localparam logic [15:0] HOLD_MS_RST  = 16'd650;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // one frame to be drawn: a colour, and for a chase the one lit pixel
    typedef struct packed {
        t_rgb             rgb;
        logic             chase;
        logic [PIX_W-1:0] lit;
    } t_frame;

    localparam t_rgb RGB_OFF = '{red: 8'd0, green: 8'd0, blue: 8'd0};

    function automatic logic [1:0] mode_style(input logic [3:0] mode);
        case (mode)
            4'd1, 4'd3, 4'd4, 4'd5, 4'd6, 4'd9: mode_style = STYLE_CHASE;
            4'd2, 4'd7, 4'd10:                  mode_style = STYLE_SOLID;
            4'd8:                               mode_style = STYLE_BLINK;
            default:                            mode_style = STYLE_DARK;
        endcase
    endfunction

    function automatic t_rgb mode_rgb(input logic [3:0] mode);
        case (mode)
            4'd1:    mode_rgb = '{red: 8'd24, green: 8'd24, blue: 8'd24};
            4'd2:    mode_rgb = '{red: 8'd0,  green: 8'd0,  blue: 8'd4};
            4'd3:    mode_rgb = '{red: 8'd0,  green: 8'd18, blue: 8'd0};
            4'd4:    mode_rgb = '{red: 8'd0,  green: 8'd8,  blue: 8'd18};
            4'd5:    mode_rgb = '{red: 8'd22, green: 8'd10, blue: 8'd0};
            4'd6:    mode_rgb = '{red: 8'd12, green: 8'd0,  blue: 8'd20};
            4'd7:    mode_rgb = '{red: 8'd24, green: 8'd0,  blue: 8'd0};
            4'd8:    mode_rgb = '{red: 8'd24, green: 8'd0,  blue: 8'd0};
            4'd9:    mode_rgb = '{red: 8'd0,  green: 8'd12, blue: 8'd10};
            4'd10:   mode_rgb = '{red: 8'd0,  green: 8'd18, blue: 8'd4};
            default: mode_rgb = RGB_OFF;
        endcase
    endfunction

    function automatic t_rgb event_rgb(input logic [1:0] ev);
        case (ev)
            2'd0:    event_rgb = '{red: 8'd0,  green: 8'd18, blue: 8'd0};
            2'd1:    event_rgb = '{red: 8'd24, green: 8'd12, blue: 8'd0};
            2'd2:    event_rgb = '{red: 8'd24, green: 8'd0,  blue: 8'd0};
            default: event_rgb = '{red: 8'd24, green: 8'd16, blue: 8'd0};
        endcase
    endfunction

    function automatic t_frame solid_frame(input t_rgb rgb);
        t_frame f;
        f.rgb   = rgb;
        f.chase = 1'b0;
        f.lit   = '0;
        solid_frame = f;
    endfunction

    // frame of the current mode for a given phase and phase mod strip length
    function automatic t_frame mode_frame(input logic [3:0] mode,
                                          input logic [7:0] phase,
                                          input logic [PIX_W-1:0] lit);
        t_frame f;
        f = solid_frame(RGB_OFF);
        case (mode_style(mode))
            STYLE_SOLID: f.rgb = mode_rgb(mode);
            STYLE_BLINK: f.rgb = phase[0] ? mode_rgb(mode) : RGB_OFF;
            STYLE_CHASE: begin
                f.rgb   = mode_rgb(mode);
                f.chase = 1'b1;
                f.lit   = lit;
            end
            default: f.rgb = RGB_OFF;
        endcase
        mode_frame = f;
    endfunction

endpackage

// ----- hdl/slps_front.sv -----
// ----------------------------------------------------------------------------
// slps_front
// command decode, mode and event state, frame timer; posts frames to the queue
// ----------------------------------------------------------------------------
module slps_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  logic [1:0]            i_opcode,
    input  logic [31:0]           i_now_ms,
    input  logic [3:0]            i_mode_code,
    input  logic [1:0]            i_event_code,
    input  logic                  i_led_enabled,
    input  logic [15:0]           i_frame_period_ms,
    input  logic [15:0]           i_event_hold_ms,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output slps_pkg::t_frame      o_frame
);

    logic [3:0]                   r_mode,     n_mode;
    logic [7:0]                   r_phase,    n_phase;
    logic [slps_pkg::PIX_W-1:0]   r_lit,      n_lit;
    logic [31:0]                  r_last,     n_last;
    logic                         r_pending,  n_pending;
    logic [1:0]                   r_held,     n_held;
    logic [31:0]                  r_deadline, n_deadline;

    logic                         accept;
    logic [31:0]                  ev_diff;
    logic [31:0]                  elapsed;
    logic [7:0]                   phase_inc;
    logic [slps_pkg::PIX_W-1:0]   lit_inc;

    assign o_cmd_ready = !i_queue_full;
    assign accept      = i_cmd_valid && !i_queue_full;
    assign ev_diff     = i_now_ms - r_deadline;
    assign elapsed     = i_now_ms - r_last;
    assign phase_inc   = r_phase + 8'd1;
    // lit tracks phase mod strip length; the 8-bit phase wrap restarts it at zero
    assign lit_inc     = (r_lit == slps_pkg::PIX_LAST || phase_inc == 8'd0) ?
                         '0 : r_lit + 1'b1;

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_lit      = r_lit;
        n_last     = r_last;
        n_pending  = r_pending;
        n_held     = r_held;
        n_deadline = r_deadline;
        o_push     = 1'b0;
        o_frame    = slps_pkg::solid_frame(slps_pkg::RGB_OFF);
        if (accept) begin
            case (i_opcode)
                slps_pkg::OP_POLL: begin
                    if (!i_led_enabled) begin
                        o_push = 1'b1;
                    end else if (r_pending && ev_diff[31]) begin
                        o_push  = 1'b1;
                        o_frame = slps_pkg::solid_frame(slps_pkg::event_rgb(r_held));
                    end else begin
                        // expired event falls through to the frame timer
                        n_pending = 1'b0;
                        if (elapsed >= {16'd0, i_frame_period_ms}) begin
                            n_last  = i_now_ms;
                            n_phase = phase_inc;
                            n_lit   = lit_inc;
                            o_push  = 1'b1;
                            o_frame = slps_pkg::mode_frame(r_mode, phase_inc, lit_inc);
                        end
                    end
                end
                slps_pkg::OP_MODE: begin
                    n_mode  = i_mode_code;
                    n_phase = '0;
                    n_lit   = '0;
                    n_last  = '0;
                    o_push  = i_led_enabled;
                    o_frame = slps_pkg::mode_frame(i_mode_code, 8'd0, '0);
                end
                slps_pkg::OP_EVENT: begin
                    if (i_led_enabled) begin
                        n_held     = i_event_code;
                        n_pending  = 1'b1;
                        n_deadline = i_now_ms + {16'd0, i_event_hold_ms};
                        o_push     = 1'b1;
                        o_frame    = slps_pkg::solid_frame(
                                         slps_pkg::event_rgb(i_event_code));
                    end
                end
                default: begin
                    n_mode    = '0;
                    n_pending = 1'b0;
                    o_push    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_phase    <= '0;
            r_lit      <= '0;
            r_last     <= '0;
            r_pending  <= 1'b0;
            r_held     <= '0;
            r_deadline <= '0;
        end else begin
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_lit      <= n_lit;
            r_last     <= n_last;
            r_pending  <= n_pending;
            r_held     <= n_held;
            r_deadline <= n_deadline;
        end
    end

endmodule

// ----- hdl/slps_queue.sv -----
// ----------------------------------------------------------------------------
// slps_queue
// two-entry frame queue between command front and pixel back
// ----------------------------------------------------------------------------
module slps_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  slps_pkg::t_frame i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output slps_pkg::t_frame o_frame
);

    slps_pkg::t_frame r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/slps_back.sv -----
// ----------------------------------------------------------------------------
// slps_back
// walks the strip for the frame at the queue head, one pixel per transfer
// ----------------------------------------------------------------------------
module slps_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  slps_pkg::t_frame            i_frame,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [slps_pkg::PIX_W-1:0]  o_pixel_index,
    output slps_pkg::t_rgb              o_rgb,
    output logic                        o_last
);

    logic [slps_pkg::PIX_W-1:0] r_pix;
    logic                       r_valid;
    logic [slps_pkg::PIX_W-1:0] r_index;
    slps_pkg::t_rgb             r_rgb;
    logic                       r_last;
    logic                       load;
    logic                       end_of_frame;

    assign load         = (!r_valid || i_ready) && !i_empty;
    assign end_of_frame = (r_pix == slps_pkg::PIX_LAST);
    assign o_pop        = load && end_of_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pix   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pix   <= end_of_frame ? '0 : r_pix + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_index <= r_pix;
            r_last  <= end_of_frame;
            if (i_frame.chase && (r_pix != i_frame.lit)) begin
                r_rgb <= slps_pkg::RGB_OFF;
            end else begin
                r_rgb <= i_frame.rgb;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_index = r_index;
    assign o_rgb         = r_rgb;
    assign o_last        = r_last;

endmodule

// ----- hdl/status_led_pattern_sequencer.sv -----
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer
// status strip sequencer: poll, set mode, event and off commands in,
// one pixel colour per output transfer out
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata now/mode/event
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata index/rgb, tlast frame end
//  cfg       in   i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
//  a command is decoded in the cycle of its transfer; a frame it draws is written
//  to the frame queue, then loaded into the output register, and leaves as
//  PIXEL_COUNT transfers, one per cycle while m_axis_tready is high; the output
//  port is the rate-setting part
//  commands keep being taken while the two-entry frame queue has room, so a
//  stalled output holds off input only once two frames are waiting
//  reset is synchronous, active low; config is always ready
// ----------------------------------------------------------------------------
module status_led_pattern_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // now_ms[31:0], mode_code[35:32], event_code[37:36]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
    output logic        m_axis_tlast,   // frame_last
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    logic        r_led_enabled;
    logic [15:0] r_frame_period_ms;
    logic [15:0] r_event_hold_ms;

    // front to queue
    logic             push;
    slps_pkg::t_frame push_frame;
    logic             queue_full;

    // queue to back
    logic             pop;
    logic             queue_empty;
    slps_pkg::t_frame head_frame;

    logic [slps_pkg::PIX_W-1:0] pixel_index;
    slps_pkg::t_rgb             pixel_rgb;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_enabled     <= 1'b1;
            r_frame_period_ms <= slps_pkg::FRAME_MS_RST;
            r_event_hold_ms   <= slps_pkg::HOLD_MS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slps_pkg::REG_ENABLE: r_led_enabled     <= i_cfg_data[0];
                slps_pkg::REG_FRAME:  r_frame_period_ms <= i_cfg_data;
                slps_pkg::REG_HOLD:   r_event_hold_ms   <= i_cfg_data;
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    // command decode and sequencing state
    slps_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (s_axis_tvalid),
        .o_cmd_ready       (s_axis_tready),
        .i_opcode          (s_axis_tuser),
        .i_now_ms          (s_axis_tdata[31:0]),
        .i_mode_code       (s_axis_tdata[35:32]),
        .i_event_code      (s_axis_tdata[37:36]),
        .i_led_enabled     (r_led_enabled),
        .i_frame_period_ms (r_frame_period_ms),
        .i_event_hold_ms   (r_event_hold_ms),
        .i_queue_full      (queue_full),
        .o_push            (push),
        .o_frame           (push_frame)
    );

    // frame descriptors waiting to be drawn
    slps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_frame (head_frame)
    );

    // pixel walker with output register
    slps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (queue_empty),
        .i_frame       (head_frame),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_pixel_index (pixel_index),
        .o_rgb         (pixel_rgb),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, pixel_rgb.blue, pixel_rgb.green, pixel_rgb.red,
                           pixel_index};

endmodule
